// ===== rtl/spa_pkg.sv =====
// spa_pkg: types, constants and CORDIC angle table for the scattering phase average core.
// No dependencies; used by every other file in rtl/ except spa_divider.
package spa_pkg;

   localparam int COUNT_BITS_DEF    = 20;
   localparam int CORDIC_STAGES_DEF = 16;

   localparam logic signed [42:0] PH_TWO_PI   = 43'sd105414357;
   localparam logic signed [42:0] PH_PI       = 43'sd52707179;
   localparam logic signed [42:0] PH_HALF_PI  = 43'sd26353589;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   typedef struct packed {
      logic signed [23:0] start_x;
      logic signed [23:0] start_y;
      logic signed [23:0] start_z;
      logic signed [23:0] end_x;
      logic signed [23:0] end_y;
      logic signed [23:0] end_z;
      logic signed [15:0] wave_x;
      logic signed [15:0] wave_y;
      logic signed [15:0] wave_z;
      logic               last;
   } req_type;

   typedef struct packed {
      logic signed [15:0] mean_real;
      logic signed [15:0] mean_imag;
      logic [20:0]        item_count;
      logic               overflow;
   } rsp_type;

   // Data handed from one CORDIC cell to the next.
   typedef struct packed {
      logic               vld;
      logic               last;
      logic               neg;
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [27:0] z;
   } cell_type;

   function automatic logic signed [27:0] atan_q24(input logic [4:0] idx);
      case (idx)
         5'd0:  atan_q24 = 28'sd13176795;
         5'd1:  atan_q24 = 28'sd7778716;
         5'd2:  atan_q24 = 28'sd4110060;
         5'd3:  atan_q24 = 28'sd2086331;
         5'd4:  atan_q24 = 28'sd1047214;
         5'd5:  atan_q24 = 28'sd524117;
         5'd6:  atan_q24 = 28'sd262123;
         5'd7:  atan_q24 = 28'sd131069;
         5'd8:  atan_q24 = 28'sd65536;
         5'd9:  atan_q24 = 28'sd32768;
         5'd10: atan_q24 = 28'sd16384;
         5'd11: atan_q24 = 28'sd8192;
         5'd12: atan_q24 = 28'sd4096;
         5'd13: atan_q24 = 28'sd2048;
         5'd14: atan_q24 = 28'sd1024;
         5'd15: atan_q24 = 28'sd512;
         5'd16: atan_q24 = 28'sd256;
         5'd17: atan_q24 = 28'sd128;
         5'd18: atan_q24 = 28'sd64;
         5'd19: atan_q24 = 28'sd32;
         5'd20: atan_q24 = 28'sd16;
         5'd21: atan_q24 = 28'sd8;
         5'd22: atan_q24 = 28'sd4;
         5'd23: atan_q24 = 28'sd2;
         default: atan_q24 = 28'sd0;
      endcase
   endfunction

endpackage

// ===== rtl/spa_cell.sv =====
// spa_cell: one CORDIC rotation cell with fixed shift STAGE.
// Depends on spa_pkg.
module spa_cell #(
   parameter int STAGE = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  spa_pkg::cell_type  cin,
   output spa_pkg::cell_type  cout
);
   spa_pkg::cell_type cell_ff, cell_in;
   logic signed [33:0] xs, ys;

   always_comb begin
      xs = cin.x >>> STAGE;
      ys = cin.y >>> STAGE;
      cell_in = cin;
      if (cin.z >= 0) begin
         cell_in.x = cin.x - ys;
         cell_in.y = cin.y + xs;
         cell_in.z = cin.z - spa_pkg::atan_q24(5'(STAGE));
      end else begin
         cell_in.x = cin.x + ys;
         cell_in.y = cin.y - xs;
         cell_in.z = cin.z + spa_pkg::atan_q24(5'(STAGE));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.vld <= 1'b0;
      end else if (adv) begin
         cell_ff <= cell_in;
      end
   end

   assign cout = cell_ff;
endmodule

// ===== rtl/spa_divider.sv =====
// spa_divider: restoring divider, one quotient bit per cycle, for the run means.
// No dependency on spa_pkg; standalone arithmetic.
module spa_divider #(
   parameter int NUM_BITS = 38,
   parameter int DEN_BITS = 33
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_BITS-1:0]  num,
   input  logic [DEN_BITS-1:0]  den,
   output logic                 done,
   output logic [NUM_BITS-1:0]  quot
);
   localparam int CW = $clog2(NUM_BITS + 1);
   logic [NUM_BITS-1:0] q_ff, q_in;
   logic [DEN_BITS:0]   r_ff, r_in;
   logic [DEN_BITS-1:0] d_ff;
   logic [CW-1:0]       n_ff;
   logic                busy_ff;
   logic [DEN_BITS:0]   trial;

   always_comb begin
      trial = {r_ff[DEN_BITS-1:0], q_ff[NUM_BITS-1]};
      q_in  = {q_ff[NUM_BITS-2:0], 1'b0};
      r_in  = trial;
      if (trial >= {1'b0, d_ff}) begin
         r_in = trial - {1'b0, d_ff};
         q_in[0] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done    <= 1'b0;
      end else begin
         done <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            q_ff <= num;
            r_ff <= '0;
            d_ff <= den;
            n_ff <= CW'(NUM_BITS);
         end else if (busy_ff) begin
            q_ff <= q_in;
            r_ff <= r_in;
            n_ff <= n_ff - 1'b1;
            if (n_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done    <= 1'b1;
            end
         end
      end
   end

   assign quot = q_ff;
endmodule

// ===== rtl/scattering_phase_average_core.sv =====
// scattering_phase_average_core: streaming mean of exp(i q.(end - start)).
// Depends on spa_pkg, spa_cell, spa_divider.
//
// Usage:
//   req_ channel carries one position pair and q vector per transfer
//   (spa_pkg::req_type). rsp_ channel returns one spa_pkg::rsp_type per
//   run, after the transfer marked last.
//   Each item goes through a phase front end (products, phase sum,
//   quotient estimate by 1/(2*pi), coarse remainder), a chain of
//   CORDIC_STAGES rotation cells and a rounding/accumulate stage. Within a
//   run items are taken one per cycle: the chain advances in every cycle
//   while no run is closing.
//   A last item closes the run: input is then held off while two
//   restoring dividers (one quotient bit per cycle) form the means,
//   and the result sits in an output register until taken.
//   The next transfer is accepted in the cycle after the result transfer.
//   The modulo reduction uses a multiply by 1/(2*pi) plus correction.
//   Reset (synchronous) clears sums, count, flag and all valid bits.
//   A stalled receiver holds the result; input stays closed from the
//   last transfer until the result transfer.
module scattering_phase_average_core #(
   parameter int COUNT_BITS    = spa_pkg::COUNT_BITS_DEF,
   parameter int CORDIC_STAGES = spa_pkg::CORDIC_STAGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  spa_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output spa_pkg::rsp_type  rsp_data
);
   localparam int CB = COUNT_BITS + 1;

   typedef enum logic [1:0] {S_RUN, S_DIV, S_OUT} state_type;
   state_type state_ff;

   // Holds off items while a run is closing anywhere in the pipe.
   logic closing_ff;
   logic adv;
   logic acc_take;

   // Front end stage 1: displacement products.
   logic               f1_vld_ff, f1_last_ff;
   logic signed [42:0] f1_px_ff, f1_py_ff, f1_pz_ff;
   logic signed [24:0] dx, dy, dz;

   assign dx = 25'(req_data.end_x) - 25'(req_data.start_x);
   assign dy = 25'(req_data.end_y) - 25'(req_data.start_y);
   assign dz = 25'(req_data.end_z) - 25'(req_data.start_z);

   assign req_ready = adv && !closing_ff && (state_ff == S_RUN);
   logic req_take;
   assign req_take = req_valid && req_ready;

   // Front end stage 2: phase sum.
   logic               f2_vld_ff, f2_last_ff;
   logic signed [42:0] f2_ph_ff;
   logic signed [42:0] ph_sum;
   assign ph_sum = f1_px_ff + f1_py_ff + f1_pz_ff;

   // Stage 3: quotient estimate by 1/(2*pi).
   // floor(ph / 2^24 ) * 1/(2pi) approx; 2^32/(2pi)=683565276
   logic               f3_vld_ff, f3_last_ff;
   logic signed [42:0] f3_ph_ff;
   logic signed [18:0] ph_hi;
   logic signed [51:0] q_prod;
   logic signed [18:0] q_est_ff;
   assign ph_hi  = f2_ph_ff[42:24];
   assign q_prod = 52'(ph_hi) * 52'sd683565276;

   // Stage 4: coarse remainder.
   logic               f4_vld_ff, f4_last_ff;
   logic signed [42:0] f4_rem_ff;
   logic signed [42:0] qm;
   assign qm = 43'(q_est_ff) * spa_pkg::PH_TWO_PI;

   // Remainder correction and folding, ahead of the first cell.
   logic signed [42:0] rem1;
   logic signed [27:0] z_f;
   logic               neg_f;
   spa_pkg::cell_type  chain [0:CORDIC_STAGES];

   always_comb begin
      rem1 = f4_rem_ff;
      if (rem1 < 0) rem1 = rem1 + spa_pkg::PH_TWO_PI;
      if (rem1 < 0) rem1 = rem1 + spa_pkg::PH_TWO_PI;
      if (rem1 >= spa_pkg::PH_TWO_PI) rem1 = rem1 - spa_pkg::PH_TWO_PI;
      if (rem1 >= spa_pkg::PH_TWO_PI) rem1 = rem1 - spa_pkg::PH_TWO_PI;
      if (rem1 >= spa_pkg::PH_PI) rem1 = rem1 - spa_pkg::PH_TWO_PI;
      neg_f = 1'b0;
      if (rem1 > spa_pkg::PH_HALF_PI) begin
         rem1 = rem1 - spa_pkg::PH_PI;
         neg_f = 1'b1;
      end else if (rem1 < -spa_pkg::PH_HALF_PI) begin
         rem1 = rem1 + spa_pkg::PH_PI;
         neg_f = 1'b1;
      end
      z_f = rem1[27:0];
      chain[0].vld  = f4_vld_ff;
      chain[0].last = f4_last_ff;
      chain[0].neg  = neg_f;
      chain[0].x    = spa_pkg::CORDIC_GAIN;
      chain[0].y    = '0;
      chain[0].z    = z_f;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
         f3_vld_ff <= 1'b0;
         f4_vld_ff <= 1'b0;
      end else if (adv) begin
         f1_vld_ff  <= req_take;
         f1_last_ff <= req_data.last;
         f1_px_ff   <= 43'(req_data.wave_x) * 43'(dx);
         f1_py_ff   <= 43'(req_data.wave_y) * 43'(dy);
         f1_pz_ff   <= 43'(req_data.wave_z) * 43'(dz);
         f2_vld_ff  <= f1_vld_ff;
         f2_last_ff <= f1_last_ff;
         f2_ph_ff   <= ph_sum;
         f3_vld_ff  <= f2_vld_ff;
         f3_last_ff <= f2_last_ff;
         f3_ph_ff   <= f2_ph_ff;
         q_est_ff   <= q_prod[50:32];
         f4_vld_ff  <= f3_vld_ff;
         f4_last_ff <= f3_last_ff;
         f4_rem_ff  <= f3_ph_ff - qm;
      end
   end

   genvar g;
   generate
      for (g = 0; g < CORDIC_STAGES; g++) begin : g_cell
         spa_cell #(.STAGE(g)) u_cell (
            .clock (clock),
            .reset (reset),
            .adv   (adv),
            .cin   (chain[g]),
            .cout  (chain[g+1])
         );
      end
   endgenerate

   // Accumulator stage.
   spa_pkg::cell_type  tail;
   logic signed [33:0] xf, yf, xr, yr;
   logic signed [15:0] c16, s16;
   assign tail = chain[CORDIC_STAGES];

   function automatic logic signed [15:0] sat_r(input logic signed [33:0] v);
      logic signed [33:0] r;
      r = (v + 34'sd16384) >>> 15;
      if (r > 34'sd32767) sat_r = 16'sh7fff;
      else if (r < -34'sd32768) sat_r = 16'sh8000;
      else sat_r = r[15:0];
   endfunction

   always_comb begin
      xf  = tail.neg ? -tail.x : tail.x;
      yf  = tail.neg ? -tail.y : tail.y;
      xr  = xf;
      yr  = yf;
      c16 = sat_r(xr);
      s16 = sat_r(yr);
   end

   assign adv      = (state_ff == S_RUN);
   assign acc_take = adv && tail.vld;

   logic signed [37:0] rsum_ff, isum_ff;
   logic [CB-1:0]      cnt_ff;
   logic               ovf_ff;
   logic               full;
   assign full = cnt_ff[CB-1];

   // Divider inputs: magnitude plus half count.
   logic [37:0] rmag, imag_m, rnum, inum, rq, iq;
   logic        rdone, idone, div_start_ff, rneg_ff, ineg_ff;
   logic [32:0] den;
   assign den    = 33'(cnt_ff);
   assign rmag   = rsum_ff[37] ? 38'(-rsum_ff) : 38'(rsum_ff);
   assign imag_m = isum_ff[37] ? 38'(-isum_ff) : 38'(isum_ff);
   assign rnum   = rmag + 38'(cnt_ff >> 1);
   assign inum   = imag_m + 38'(cnt_ff >> 1);

   spa_divider #(.NUM_BITS(38), .DEN_BITS(33)) u_div_re (
      .clock(clock), .reset(reset), .start(div_start_ff),
      .num(rnum), .den(den), .done(rdone), .quot(rq)
   );
   spa_divider #(.NUM_BITS(38), .DEN_BITS(33)) u_div_im (
      .clock(clock), .reset(reset), .start(div_start_ff),
      .num(inum), .den(den), .done(idone), .quot(iq)
   );

   function automatic logic signed [15:0] mean_sat(input logic [37:0] q,
                                                   input logic neg);
      if (neg) mean_sat = (q >= 38'd32768) ? 16'sh8000 : -16'(q);
      else     mean_sat = (q >= 38'd32767) ? 16'sh7fff : 16'(q);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RUN;
         closing_ff   <= 1'b0;
         rsum_ff      <= '0;
         isum_ff      <= '0;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid    <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         if (req_take && req_data.last) closing_ff <= 1'b1;
         case (state_ff)
            S_RUN: begin
               if (acc_take) begin
                  if (full) begin
                     ovf_ff <= 1'b1;
                  end else begin
                     rsum_ff <= rsum_ff + 38'(c16);
                     isum_ff <= isum_ff + 38'(s16);
                     cnt_ff  <= cnt_ff + 1'b1;
                  end
                  if (tail.last) begin
                     state_ff     <= S_DIV;
                     div_start_ff <= 1'b1;
                  end
               end
            end
            S_DIV: begin
               if (div_start_ff) begin
                  rneg_ff <= rsum_ff[37];
                  ineg_ff <= isum_ff[37];
               end
               if (rdone && idone) begin
                  rsp_data.mean_real  <= mean_sat(rq, rneg_ff);
                  rsp_data.mean_imag  <= mean_sat(iq, ineg_ff);
                  rsp_data.item_count <= 21'(cnt_ff);
                  rsp_data.overflow   <= ovf_ff;
                  rsp_valid  <= 1'b1;
                  rsum_ff    <= '0;
                  isum_ff    <= '0;
                  cnt_ff     <= '0;
                  ovf_ff     <= 1'b0;
                  state_ff   <= S_OUT;
               end
            end
            S_OUT: begin
               if (rsp_ready) begin
                  rsp_valid  <= 1'b0;
                  closing_ff <= 1'b0;
                  state_ff   <= S_RUN;
               end
            end
            default: state_ff <= S_RUN;
         endcase
      end
   end
endmodule

// ===== rtl/spa_checker.sv =====
// spa_checker: port-level assertions for scattering_phase_average_core.
// Depends on spa_pkg; bound to the top level below.
module spa_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input spa_pkg::req_type  req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input spa_pkg::rsp_type  rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");
   a_no_req_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while a result waits");
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.item_count != 21'd0 || rsp_data.overflow))
      else $error("empty run reported");
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.last |=> !req_ready)
      else $error("input open after last transfer");
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
endmodule

bind scattering_phase_average_core spa_checker u_spa_checker (.*);
